@@ design/rps_pkg.sv @@
package rps_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int DRAW_BITS_DEF   = 16;

    localparam int DRAW_W  = 16;   // s_axis_tdata field width
    localparam int VALUE_W = 8;    // m_axis_tdata field width
    localparam int SIZE_W  = 9;    // list_size register width
    localparam int SIZE_RST = 256;

    typedef enum logic [3:0] {
        S_REFILL,
        S_IDLE,
        S_MUL,
        S_READ,
        S_WR_I,
        S_WR_J,
        S_EMIT,
        S_RD_LAST,
        S_RD_ZERO,
        S_EMIT_LAST
    } t_state;

    typedef struct packed {
        logic take_draw;   // latch draw word from accepted beat
        logic refill_wr;   // identity write at refill counter
        logic mul;         // scale draw by remaining span
        logic rd_swap;     // read entries i and j, latch j
        logic rd_last;     // read entry n-1 on port a
        logic rd_zero;     // read entry 0 on port a
        logic wr_i;        // store[i] <= old store[j]
        logic wr_j;        // store[j] <= old store[i]
        logic out_mid;     // load output with swapped value, not last
        logic out_last;    // load output with port a value, last
        logic pos_inc;
        logic pos_clr;
    } t_cmd;

    typedef struct packed {
        logic refill_done;
        logic size_one;
        logic at_end;      // position == n-2
        logic out_free;
    } t_status;

endpackage

@@ design/rps_ctrl.sv @@
module rps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rps_pkg::t_status  i_status,
    output rps_pkg::t_cmd     o_cmd
);

    rps_pkg::t_state r_state;
    rps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rps_pkg::S_REFILL;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rps_pkg::S_REFILL: begin
                if (i_status.refill_done) n_state = rps_pkg::S_IDLE;
            end
            rps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.size_one ? rps_pkg::S_RD_ZERO : rps_pkg::S_MUL;
                end
            end
            rps_pkg::S_MUL:    n_state = rps_pkg::S_READ;
            rps_pkg::S_READ:   n_state = rps_pkg::S_WR_I;
            rps_pkg::S_WR_I:   n_state = rps_pkg::S_WR_J;
            rps_pkg::S_WR_J:   n_state = rps_pkg::S_EMIT;
            rps_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.at_end ? rps_pkg::S_RD_LAST : rps_pkg::S_IDLE;
                end
            end
            rps_pkg::S_RD_LAST: n_state = rps_pkg::S_EMIT_LAST;
            rps_pkg::S_RD_ZERO: n_state = rps_pkg::S_EMIT_LAST;
            rps_pkg::S_EMIT_LAST: begin
                if (i_status.out_free) n_state = rps_pkg::S_IDLE;
            end
            default: n_state = rps_pkg::S_REFILL;
        endcase
        // size write restarts the identity refill
        if (i_cfg_wr_en) n_state = rps_pkg::S_REFILL;
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rps_pkg::S_REFILL: o_cmd.refill_wr = 1'b1;
            rps_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.take_draw = i_in_valid;
            end
            rps_pkg::S_MUL:  o_cmd.mul     = 1'b1;
            rps_pkg::S_READ: o_cmd.rd_swap = 1'b1;
            rps_pkg::S_WR_I: o_cmd.wr_i    = 1'b1;
            rps_pkg::S_WR_J: o_cmd.wr_j    = 1'b1;
            rps_pkg::S_EMIT: begin
                o_cmd.out_mid = i_status.out_free;
                o_cmd.pos_inc = i_status.out_free & ~i_status.at_end;
            end
            rps_pkg::S_RD_LAST: o_cmd.rd_last = 1'b1;
            rps_pkg::S_RD_ZERO: o_cmd.rd_zero = 1'b1;
            rps_pkg::S_EMIT_LAST: begin
                o_cmd.out_last = i_status.out_free;
                o_cmd.pos_clr  = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ design/rps_datapath.sv @@
module rps_datapath #(
    parameter int MAX_ENTRIES = rps_pkg::MAX_ENTRIES_DEF,
    parameter int DRAW_BITS   = rps_pkg::DRAW_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [rps_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    input  logic [rps_pkg::DRAW_W-1:0]   i_draw,
    input  rps_pkg::t_cmd                i_cmd,
    output rps_pkg::t_status             o_status,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rps_pkg::VALUE_W-1:0]  o_out_value,
    output logic                         o_out_last
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = DRAW_BITS + NW;
    localparam int RST_SIZE = (rps_pkg::SIZE_RST > MAX_ENTRIES) ? MAX_ENTRIES
                                                                : rps_pkg::SIZE_RST;

    logic [AW-1:0] r_store [MAX_ENTRIES];

    logic [NW-1:0]        r_size;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        r_fill_cnt;
    logic [DRAW_BITS-1:0] r_draw;
    logic [PW-1:0]        r_prod;
    logic [AW-1:0]        r_j;
    logic [AW-1:0]        r_rd_a;
    logic [AW-1:0]        r_rd_b;
    logic                 r_out_valid;
    logic [AW-1:0]        r_out_value;
    logic                 r_out_last;

    logic [NW-1:0]  n_size;
    logic [NW-1:0]  remaining;
    logic [NW:0]    j_sum;
    logic [AW-1:0]  j_idx;
    logic [AW-1:0]  last_idx;
    logic [AW-1:0]  rd_a_addr;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  wr_data;
    logic           wr_en;

    // clamp written size to 1..MAX_ENTRIES
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            n_size = NW'(1);
        end else if (32'(i_cfg_wr_data) > 32'(MAX_ENTRIES)) begin
            n_size = NW'(MAX_ENTRIES);
        end else begin
            n_size = NW'(i_cfg_wr_data);
        end
    end

    assign remaining = r_size - NW'(r_pos);
    assign last_idx  = AW'(r_size - NW'(1));

    // j = position + ((draw * remaining) >> DRAW_BITS), capped at n-1
    assign j_sum = (NW+1)'(r_pos) + (NW+1)'(r_prod[PW-1:DRAW_BITS]);
    assign j_idx = (j_sum >= (NW+1)'(r_size)) ? last_idx : AW'(j_sum);

    always_comb begin
        rd_a_addr = r_pos;
        if (i_cmd.rd_last) rd_a_addr = last_idx;
        if (i_cmd.rd_zero) rd_a_addr = '0;
    end

    always_comb begin
        wr_en   = i_cmd.refill_wr | i_cmd.wr_i | i_cmd.wr_j;
        wr_addr = r_fill_cnt;
        wr_data = r_fill_cnt;
        if (i_cmd.wr_i) begin
            wr_addr = r_pos;
            wr_data = r_rd_b;
        end else if (i_cmd.wr_j) begin
            wr_addr = r_j;
            wr_data = r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_store[wr_addr] <= wr_data;
        if (i_cmd.rd_swap | i_cmd.rd_last | i_cmd.rd_zero) r_rd_a <= r_store[rd_a_addr];
        if (i_cmd.rd_swap) r_rd_b <= r_store[j_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_draw) r_draw <= DRAW_BITS'(i_draw);
        if (i_cmd.mul)       r_prod <= PW'(r_draw) * PW'(remaining);
        if (i_cmd.rd_swap)   r_j    <= j_idx;
        if (i_cmd.out_mid) begin
            r_out_value <= r_rd_b;
            r_out_last  <= 1'b0;
        end else if (i_cmd.out_last) begin
            r_out_value <= r_rd_a;
            r_out_last  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= NW'(RST_SIZE);
            r_pos       <= '0;
            r_fill_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_size     <= n_size;
                r_pos      <= '0;
                r_fill_cnt <= '0;
            end else begin
                if (i_cmd.refill_wr) r_fill_cnt <= r_fill_cnt + AW'(1);
                if (i_cmd.pos_inc)   r_pos <= r_pos + AW'(1);
                if (i_cmd.pos_clr)   r_pos <= '0;
            end
            if (i_cmd.out_mid | i_cmd.out_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.refill_done = (r_fill_cnt == AW'(MAX_ENTRIES - 1));
    assign o_status.size_one    = (r_size < NW'(2));
    assign o_status.at_end      = (NW'(r_pos) == r_size - NW'(2));
    assign o_status.out_free    = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_value = rps_pkg::VALUE_W'(r_out_value);
    assign o_out_last  = r_out_last;

endmodule

@@ design/random_permutation_shuffler.sv @@
// Channel   Dir  Beat contents
// s_axis    in   tdata[15:0] random_draw
// m_axis    out  tdata[7:0] perm_value, tlast last_of_run
// cfg       in   i_cfg_wr_data[8:0] list_size, written when i_cfg_wr_en
//
// An accepted draw steps through multiply, dual read, two single-port writes
// for the swap and the output load; no new beat is taken until it has loaded.
// At position n-2 the step then loads entry n-1 as the final entry.
// With n = 1 entry 0 is read and loaded as the final entry, with no swap.
// After reset and after each size write the store is refilled with the
// identity, one entry per cycle over all entries; s_axis_tready is low.
// A stalled m_axis holds the result register; the next draw is taken meanwhile.
module random_permutation_shuffler #(
    parameter int MAX_ENTRIES = rps_pkg::MAX_ENTRIES_DEF,
    parameter int DRAW_BITS   = rps_pkg::DRAW_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [rps_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [rps_pkg::DRAW_W-1:0]   s_axis_tdata,   // [15:0] random_draw
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [rps_pkg::VALUE_W-1:0]  m_axis_tdata,   // [7:0] perm_value
    output logic                         m_axis_tlast
);

    rps_pkg::t_cmd    cmd;
    rps_pkg::t_status status;

    rps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rps_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DRAW_BITS   (DRAW_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_draw        (s_axis_tdata),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_value   (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

endmodule
